### sv/zcdp_pkg.sv
// ----------------------------------------------------------------------------
// ZIP central directory parser package
// Shared result type, record layout offsets, result kinds and error codes.
// ----------------------------------------------------------------------------
package zcdp_pkg;

   // Longest name prefix passed on is NameMax-1 bytes.
   localparam int NameMax = 256;
   localparam logic [15:0] NameKeepMax = 16'(NameMax - 1);

   // Fixed part of one central directory record.
   localparam logic [31:0] CdSignature = 32'h0201_4b50;
   localparam logic [32:0] FixedLen    = 33'd46;

   // Byte positions inside a record (last byte of most fields; PosFirst, PosFlags and PosNameStart mark first bytes).
   localparam logic [17:0] PosFirst     = 18'd0;
   localparam logic [17:0] PosSigEnd    = 18'd3;
   localparam logic [17:0] PosFlags     = 18'd8;
   localparam logic [17:0] PosMethodEnd = 18'd11;
   localparam logic [17:0] PosCrcEnd    = 18'd19;
   localparam logic [17:0] PosPackEnd   = 18'd23;
   localparam logic [17:0] PosPlainEnd  = 18'd27;
   localparam logic [17:0] PosNameLen   = 18'd29;
   localparam logic [17:0] PosExtraLen  = 18'd31;
   localparam logic [17:0] PosCommLen   = 18'd33;
   localparam logic [17:0] PosFixedLast = 18'd45;
   localparam logic [17:0] PosNameStart = 18'd46;
   // Largest record position: 46 fixed bytes plus three full lengths, minus one.
   localparam logic [17:0] PosMax       = 18'd196650;

   // Result kinds.
   localparam logic [1:0] KindName  = 2'd0;
   localparam logic [1:0] KindEntry = 2'd1;
   localparam logic [1:0] KindError = 2'd2;

   // Error codes.
   localparam logic [1:0] ErrHeaderPastEnd = 2'd0;
   localparam logic [1:0] ErrBadSignature  = 2'd1;
   localparam logic [1:0] ErrEncrypted     = 2'd2;
   localparam logic [1:0] ErrRecordPastEnd = 2'd3;

   // Configuration register indexes.
   localparam logic CsrDirSize = 1'b0;
   localparam logic CsrEntries = 1'b1;

   // Output queue.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  name_char;
      logic [15:0] entry_number;
      logic [15:0] comp_method;
      logic [31:0] data_crc;
      logic [31:0] packed_size;
      logic [31:0] plain_size;
      logic [31:0] header_offset;
      logic [15:0] full_name_length;
      logic [1:0]  error_code;
      logic        final_entry;
      logic        run_last;
   } result_type;

   // Results produced for one accepted byte.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

### sv/zip_central_directory_parser.sv
// ----------------------------------------------------------------------------
// ZIP central directory parser
// Parses central directory records byte by byte into name bytes, entry
// records and a sticky error word.
// ----------------------------------------------------------------------------
// The block takes one directory byte per clock cycle while req_tready is
// high. Each byte is decoded in the cycle it is accepted and its results
// go into a four-word output queue read by the result side. A byte gives
// at most two words (the last name byte of a record that also ends the
// record), and the input is ready whenever two queue slots are free; with
// the result side always ready the sustained rate is one byte per cycle.
// Program directory_size and entries_expected while the block is idle; a
// zero in either makes the block ignore every byte.
module zip_central_directory_parser (
   input  logic         clock,
   input  logic         reset,
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data,
   // Directory byte stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // dir_byte
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // name_char[7:0], entry_number[23:8], comp_method[39:24], data_crc[71:40],
   // packed_size[103:72], plain_size[135:104], header_offset[167:136],
   // full_name_length[183:168], error_code[185:184], final_entry[186], zeros
   output logic [191:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,    // kind
   output logic         rsp_tlast     // run_last
);
   import zcdp_pkg::*;

   // Configuration registers.
   logic [31:0] dir_size_ff;
   logic [15:0] entries_exp_ff;

   // Parse state.
   logic [17:0] rec_pos_ff,     rec_pos_in;
   logic [31:0] cursor_ff,      cursor_in;
   logic [15:0] done_ff,        done_in;
   logic [31:0] shift_ff,       shift_in;
   logic [15:0] method_ff,      method_in;
   logic [31:0] crc_ff,         crc_in;
   logic [31:0] packed_ff,      packed_in;
   logic [31:0] plain_ff,       plain_in;
   logic [15:0] name_len_ff,    name_len_in;
   logic [15:0] extra_len_ff,   extra_len_in;
   logic [15:0] comm_len_ff,    comm_len_in;
   logic [31:0] offset_ff,      offset_in;
   logic        halted_ff,      halted_in;
   // Running end offset of the current record, and its last byte position.
   logic [32:0] span_ff,        span_in;
   logic [17:0] rec_last_ff,    rec_last_in;

   logic        accept;
   logic        active;
   logic [31:0] shift_new;
   logic [32:0] span_full;
   logic        fail;
   logic [1:0]  fail_code;
   logic [15:0] keep;
   logic        name_hit;
   logic        rec_done;
   result_type  name_word;
   result_type  entry_word;
   result_type  error_word;
   push_type    push;
   logic        room_two;
   result_type  head;

   assign csr_ready  = 1'b1;
   assign req_tready = room_two;
   assign accept     = req_tvalid && req_tready;
   assign active     = !halted_ff && (dir_size_ff != '0) && (entries_exp_ff != '0)
                       && (done_ff < entries_exp_ff);
   assign shift_new  = {req_tdata, shift_ff[31:8]};
   assign span_full  = span_ff + {17'd0, shift_new[31:16]};
   assign keep       = (name_len_ff > NameKeepMax) ? NameKeepMax : name_len_ff;

   // Configuration writes; unknown indexes do not exist on a one-bit index.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_size_ff    <= '0;
         entries_exp_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrDirSize: dir_size_ff    <= csr_data;
            CsrEntries: entries_exp_ff <= csr_data[15:0];
            default:    ;
         endcase
      end
   end

   // Field capture and record checks for the accepted byte.
   always_comb begin
      rec_pos_in   = rec_pos_ff;
      cursor_in    = cursor_ff;
      done_in      = done_ff;
      shift_in     = shift_ff;
      method_in    = method_ff;
      crc_in       = crc_ff;
      packed_in    = packed_ff;
      plain_in     = plain_ff;
      name_len_in  = name_len_ff;
      extra_len_in = extra_len_ff;
      comm_len_in  = comm_len_ff;
      offset_in    = offset_ff;
      halted_in    = halted_ff;
      span_in      = span_ff;
      rec_last_in  = rec_last_ff;
      fail         = 1'b0;
      fail_code    = ErrHeaderPastEnd;
      name_hit     = 1'b0;
      rec_done     = 1'b0;
      push         = '0;

      if (accept && active) begin
         if (rec_pos_ff == PosFirst &&
             ({1'b0, cursor_ff} + FixedLen) > {1'b0, dir_size_ff}) begin
            fail      = 1'b1;
            fail_code = ErrHeaderPastEnd;
         end else begin
            shift_in = shift_new;
            case (rec_pos_ff)
               PosFirst: span_in = {1'b0, cursor_ff} + FixedLen;
               PosSigEnd: begin
                  if (shift_new != CdSignature) begin
                     fail      = 1'b1;
                     fail_code = ErrBadSignature;
                  end
               end
               PosFlags: begin
                  if (req_tdata[0]) begin
                     fail      = 1'b1;
                     fail_code = ErrEncrypted;
                  end
               end
               PosMethodEnd: method_in = shift_new[31:16];
               PosCrcEnd:    crc_in    = shift_new;
               PosPackEnd:   packed_in = shift_new;
               PosPlainEnd:  plain_in  = shift_new;
               PosNameLen: begin
                  name_len_in = shift_new[31:16];
                  span_in     = span_ff + {17'd0, shift_new[31:16]};
               end
               PosExtraLen: begin
                  extra_len_in = shift_new[31:16];
                  span_in      = span_ff + {17'd0, shift_new[31:16]};
               end
               PosCommLen: begin
                  comm_len_in = shift_new[31:16];
                  rec_last_in = PosFixedLast + {2'd0, name_len_ff}
                                + {2'd0, extra_len_ff} + {2'd0, shift_new[31:16]};
                  if (span_full > {1'b0, dir_size_ff}) begin
                     fail      = 1'b1;
                     fail_code = ErrRecordPastEnd;
                  end else begin
                     span_in = span_full;
                  end
               end
               PosFixedLast: offset_in = shift_new;
               default: ;
            endcase
         end

         if (fail) begin
            halted_in = 1'b1;
         end else begin
            name_hit = (rec_pos_ff >= PosNameStart) &&
                       ((rec_pos_ff - PosNameStart) < {2'd0, keep});
            rec_done = (rec_pos_ff >= PosFixedLast) && (rec_pos_ff == rec_last_ff);
            if (rec_done) begin
               done_in    = done_ff + 16'd1;
               cursor_in  = span_ff[31:0];
               rec_pos_in = '0;
            end else begin
               rec_pos_in = rec_pos_ff + 18'd1;
            end
         end
      end

      // Result words.
      error_word              = '0;
      error_word.kind         = KindError;
      error_word.entry_number = done_ff;
      error_word.error_code   = fail_code;
      error_word.run_last     = 1'b1;

      name_word              = '0;
      name_word.kind         = KindName;
      name_word.name_char    = req_tdata;
      name_word.entry_number = done_ff;
      name_word.run_last     = !rec_done;

      entry_word                  = '0;
      entry_word.kind             = KindEntry;
      entry_word.entry_number     = done_ff;
      entry_word.comp_method      = method_ff;
      entry_word.data_crc         = crc_ff;
      entry_word.packed_size      = packed_ff;
      entry_word.plain_size       = plain_ff;
      entry_word.header_offset    = offset_in;
      entry_word.full_name_length = name_len_ff;
      entry_word.final_entry      = ((done_ff + 16'd1) == entries_exp_ff);
      entry_word.run_last         = 1'b1;

      if (fail) begin
         push.count = 2'd1;
         push.first = error_word;
      end else if (name_hit && rec_done) begin
         push.count  = 2'd2;
         push.first  = name_word;
         push.second = entry_word;
      end else if (name_hit) begin
         push.count = 2'd1;
         push.first = name_word;
      end else if (rec_done) begin
         push.count = 2'd1;
         push.first = entry_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_pos_ff   <= '0;
         cursor_ff    <= '0;
         done_ff      <= '0;
         shift_ff     <= '0;
         method_ff    <= '0;
         crc_ff       <= '0;
         packed_ff    <= '0;
         plain_ff     <= '0;
         name_len_ff  <= '0;
         extra_len_ff <= '0;
         comm_len_ff  <= '0;
         offset_ff    <= '0;
         halted_ff    <= 1'b0;
         span_ff      <= '0;
         rec_last_ff  <= '0;
      end else begin
         rec_pos_ff   <= rec_pos_in;
         cursor_ff    <= cursor_in;
         done_ff      <= done_in;
         shift_ff     <= shift_in;
         method_ff    <= method_in;
         crc_ff       <= crc_in;
         packed_ff    <= packed_in;
         plain_ff     <= plain_in;
         name_len_ff  <= name_len_in;
         extra_len_ff <= extra_len_in;
         comm_len_ff  <= comm_len_in;
         offset_ff    <= offset_in;
         halted_ff    <= halted_in;
         span_ff      <= span_in;
         rec_last_ff  <= rec_last_in;
      end
   end

   // Output queue.
   zcdp_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room_two   (room_two),
      .head       (head),
      .head_valid (rsp_tvalid),
      .head_taken (rsp_tready)
   );

   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.run_last;
   assign rsp_tdata = {5'd0, head.final_entry, head.error_code, head.full_name_length,
                       head.header_offset, head.plain_size, head.packed_size,
                       head.data_crc, head.comp_method, head.entry_number,
                       head.name_char};

   // An error word halts parsing from the next cycle on.
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.first.kind == KindError) |=> halted_ff)
      else $error("error word without halt");

   // Nothing is produced once halted.
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (push.count == 2'd0))
      else $error("result after halt");

   // Two words from one byte are always a name byte followed by an entry.
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |->
         (push.first.kind == KindName && push.second.kind == KindEntry))
      else $error("bad word pair");

   // The position within a record stays inside the largest record.
   assert property (@(posedge clock) disable iff (reset)
      rec_pos_ff <= PosMax)
      else $error("record position out of range");

endmodule

### sv/zcdp_result_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two result words per cycle and
// hands out one word per cycle while the result side is ready.
// ----------------------------------------------------------------------------
module zcdp_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  zcdp_pkg::push_type  push,
   output logic                room_two,
   output zcdp_pkg::result_type head,
   output logic                head_valid,
   input  logic                head_taken
);
   import zcdp_pkg::*;

   result_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]    count_ff, count_in;
   logic                    pop;
   logic [QueuePtrW-1:0]    wr_ptr_next;

   assign pop         = head_valid && head_taken;
   assign head_valid  = (count_ff != '0);
   assign head        = slot_ff[rd_ptr_ff];
   assign room_two    = (count_ff <= QueueCntW'(QueueDepth - 2));
   assign wr_ptr_next = wr_ptr_ff + QueuePtrW'(1);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCntW'(push.count) - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: first word at the write pointer, second one after it.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_next] <= push.second;
      end
   end

   // The fill count never passes the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("result queue overflow");

   // Words are pushed only when two slots are free.
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room_two)
      else $error("push into full result queue");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the ZIP central directory parser
// Streams mostly valid central directory records with random content through
// the byte port under random stalls on both sides. A small scoreboard class
// predicts the name bytes, entry words and the one sticky error word. Each
// result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

// Predicts the parser's result words and checks the words it returns.
class cd_scoreboard;
   localparam bit [7:0] EncryptFlag = 8'h01;

   // Register copies.
   bit [31:0] dir_size;
   bit [15:0] entry_limit;

   // Parser state.
   bit [17:0] rec_pos;
   bit [31:0] rec_base;
   bit [15:0] done_count;
   bit [31:0] shift_word;
   bit [15:0] method_f;
   bit [15:0] name_len_f;
   bit [15:0] extra_len_f;
   bit [15:0] comment_len_f;
   bit [31:0] crc_f;
   bit [31:0] packed_f;
   bit [31:0] plain_f;
   bit [31:0] offset_f;
   bit        stopped;

   zcdp_pkg::result_type due_words[$];
   int unsigned mismatches;

   function void write_reg(logic index, logic [31:0] value);
      if (index == zcdp_pkg::CsrDirSize) begin
         dir_size = value;
      end else begin
         entry_limit = value[15:0];
      end
   endfunction

   // The first error ends parsing for good.
   function void push_error(logic [1:0] code);
      zcdp_pkg::result_type w;
      w = '0;
      w.kind = zcdp_pkg::KindError;
      w.entry_number = done_count;
      w.error_code = code;
      w.run_last = 1'b1;
      due_words.push_back(w);
      stopped = 1'b1;
   endfunction

   // Works out the words caused by one accepted directory byte.
   function void parse_byte(logic [7:0] b);
      zcdp_pkg::result_type w;
      bit [17:0] p;
      bit [15:0] keep;
      int unsigned span;
      int unsigned first_new;
      if (stopped || dir_size == 0 || entry_limit == 0 || done_count >= entry_limit) begin
         return;
      end
      p = rec_pos;
      first_new = due_words.size();

      // The whole fixed part must fit before a record may start.
      if (p == zcdp_pkg::PosFirst &&
          64'(rec_base) + 64'(zcdp_pkg::FixedLen) > 64'(dir_size)) begin
         push_error(zcdp_pkg::ErrHeaderPastEnd);
         return;
      end

      shift_word = {b, shift_word[31:8]};
      case (p)
         zcdp_pkg::PosSigEnd: begin
            if (shift_word != zcdp_pkg::CdSignature) begin
               push_error(zcdp_pkg::ErrBadSignature);
               return;
            end
         end
         zcdp_pkg::PosFlags: begin
            if ((b & EncryptFlag) != 0) begin
               push_error(zcdp_pkg::ErrEncrypted);
               return;
            end
         end
         zcdp_pkg::PosMethodEnd: method_f = shift_word[31:16];
         zcdp_pkg::PosCrcEnd:    crc_f = shift_word;
         zcdp_pkg::PosPackEnd:   packed_f = shift_word;
         zcdp_pkg::PosPlainEnd:  plain_f = shift_word;
         zcdp_pkg::PosNameLen:   name_len_f = shift_word[31:16];
         zcdp_pkg::PosExtraLen:  extra_len_f = shift_word[31:16];
         zcdp_pkg::PosCommLen: begin
            comment_len_f = shift_word[31:16];
            if (64'(rec_base) + 64'(zcdp_pkg::FixedLen) + 64'(name_len_f) +
                64'(extra_len_f) + 64'(comment_len_f) > 64'(dir_size)) begin
               push_error(zcdp_pkg::ErrRecordPastEnd);
               return;
            end
         end
         zcdp_pkg::PosFixedLast: offset_f = shift_word;
         default: ;
      endcase

      // Name bytes pass through up to the truncation limit.
      keep = (name_len_f > zcdp_pkg::NameKeepMax) ? zcdp_pkg::NameKeepMax : name_len_f;
      if (p >= zcdp_pkg::PosNameStart && (p - zcdp_pkg::PosNameStart) < 18'(keep)) begin
         w = '0;
         w.kind = zcdp_pkg::KindName;
         w.name_char = b;
         w.entry_number = done_count;
         due_words.push_back(w);
      end

      // The last byte of the record completes the entry.
      span = 32'(zcdp_pkg::FixedLen) + 32'(name_len_f) + 32'(extra_len_f) +
             32'(comment_len_f);
      if (p >= zcdp_pkg::PosFixedLast && 32'(p) + 1 == span) begin
         w = '0;
         w.kind = zcdp_pkg::KindEntry;
         w.entry_number = done_count;
         w.comp_method = method_f;
         w.data_crc = crc_f;
         w.packed_size = packed_f;
         w.plain_size = plain_f;
         w.header_offset = offset_f;
         w.full_name_length = name_len_f;
         w.final_entry = (32'(done_count) + 1 == 32'(entry_limit));
         due_words.push_back(w);
         done_count++;
         rec_base += span;
         rec_pos = '0;
      end else begin
         rec_pos = p + 1;
      end

      if (due_words.size() > first_new) begin
         w = due_words.pop_back();
         w.run_last = 1'b1;
         due_words.push_back(w);
      end
   endfunction

   function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatches++;
      end
   endfunction

   // Checks one accepted result word against the oldest prediction.
   function void check_word(zcdp_pkg::result_type got);
      zcdp_pkg::result_type want;
      if (due_words.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual kind %0h", $time, got.kind);
         mismatches++;
         return;
      end
      want = due_words.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("name_char", want.name_char, got.name_char);
      compare_field("entry_number", want.entry_number, got.entry_number);
      compare_field("comp_method", want.comp_method, got.comp_method);
      compare_field("data_crc", want.data_crc, got.data_crc);
      compare_field("packed_size", want.packed_size, got.packed_size);
      compare_field("plain_size", want.plain_size, got.plain_size);
      compare_field("header_offset", want.header_offset, got.header_offset);
      compare_field("full_name_length", want.full_name_length, got.full_name_length);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("final_entry", want.final_entry, got.final_entry);
      compare_field("run_last", want.run_last, got.run_last);
   endfunction
endclass

module tb_top;
   import zcdp_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int LongHold      = 300;
   localparam int DrainCycles   = 4;
   localparam int TailCycles    = 20;
   localparam int RandomBytes   = 100;

   // Record layout offsets used when building records.
   localparam int OffFlags   = 8;
   localparam int OffNameLen = 28;
   localparam int OffExtLen  = 30;
   localparam int OffComLen  = 32;
   localparam int FixedBytes = 46;

   typedef enum int {FillRandom, FillZeros, FillOnes} fill_type;
   typedef enum int {FaultNone, FaultSignature, FaultEncrypted} fault_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = CsrDirSize;
   logic [31:0]  csr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   cd_scoreboard board = new();
   logic [7:0]   rec_bytes[$];
   bit           hold_rsp = 1'b0;
   int unsigned  idle_cycles = 0;
   int unsigned  req_count = 0;
   int unsigned  rsp_count = 0;
   bit           req_burst = 1'b0;
   bit           rsp_burst = 1'b0;

   zip_central_directory_parser dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Ends the run when no channel has moved a word for too long.
   always @(negedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic logic [7:0] pick(fill_type fill);
      case (fill)
         FillZeros: return 8'h00;
         FillOnes:  return 8'hFF;
         default:   return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Builds one record: fixed part, name, extra field and comment.
   function automatic void make_record(int nlen, int xlen, int clen, fill_type fill,
                                       fault_type fault);
      int i;
      int spot;
      rec_bytes.delete();
      for (i = 0; i < FixedBytes + nlen + xlen + clen; i++) begin
         rec_bytes.push_back(pick(fill));
      end
      for (i = 0; i < 4; i++) begin
         rec_bytes[i] = CdSignature[8*i +: 8];
      end
      rec_bytes[OffFlags] = rec_bytes[OffFlags] & 8'hFE;
      rec_bytes[OffNameLen]     = 8'(nlen);
      rec_bytes[OffNameLen + 1] = 8'(nlen >> 8);
      rec_bytes[OffExtLen]      = 8'(xlen);
      rec_bytes[OffExtLen + 1]  = 8'(xlen >> 8);
      rec_bytes[OffComLen]      = 8'(clen);
      rec_bytes[OffComLen + 1]  = 8'(clen >> 8);
      if (fault == FaultSignature) begin
         spot = $urandom_range(0, 3);
         rec_bytes[spot] = rec_bytes[spot] ^ 8'(1 << $urandom_range(0, 7));
      end else if (fault == FaultEncrypted) begin
         rec_bytes[OffFlags] = rec_bytes[OffFlags] | 8'h01;
      end
   endfunction

   // Offers one byte after a random gap and waits for it to be taken.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (req_count % 32 == 0) begin
         req_burst = ($urandom_range(0, 2) == 0);
      end
      req_count++;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      board.parse_byte(value);
   endtask

   task automatic send_span(input int from, input int upto);
      int i;
      for (i = from; i < upto; i++) begin
         send_byte(rec_bytes[i]);
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Waits until every predicted word has come back and the block is quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.due_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      board.write_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random stalls, one long hold-off on request.
   initial begin : result_sink
      zcdp_pkg::result_type got;
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_count % 32 == 0) begin
            rsp_burst = ($urandom_range(0, 2) == 0);
         end
         rsp_count++;
         gap = rsp_burst ? 0 : $urandom_range(0, 9);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            gap = LongHold;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         got = '0;
         got.kind             = rsp_tuser;
         got.name_char        = rsp_tdata[7:0];
         got.entry_number     = rsp_tdata[23:8];
         got.comp_method      = rsp_tdata[39:24];
         got.data_crc         = rsp_tdata[71:40];
         got.packed_size      = rsp_tdata[103:72];
         got.plain_size       = rsp_tdata[135:104];
         got.header_offset    = rsp_tdata[167:136];
         got.full_name_length = rsp_tdata[183:168];
         got.error_code       = rsp_tdata[185:184];
         got.final_entry      = rsp_tdata[186];
         got.run_last         = rsp_tlast;
         @(posedge clock);
         board.check_word(got);
      end
   end

   initial begin : stimulus
      int useful;
      int nlen;
      int xlen;
      int clen;
      fill_type fill;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty directory: with either register at zero every byte is dropped.
      send_noise(8);
      drain();
      write_csr(CsrDirSize, 32'hFFFF_FFFF);
      send_noise(8);
      drain();
      write_csr(CsrEntries, 32'h0000_FFFF);
      write_csr(CsrDirSize, 32'h0000_0000);
      send_noise(8);
      drain();
      write_csr(CsrDirSize, 32'hFFFF_FFFF);

      // Directed records: bare fixed part, name ending the record, all three
      // variable parts together and each variable part alone.
      make_record(0, 0, 0, FillZeros, FaultNone);
      send_span(0, rec_bytes.size());
      make_record(1, 0, 0, FillOnes, FaultNone);
      send_span(0, rec_bytes.size());
      make_record(3, 2, 1, FillRandom, FaultNone);
      send_span(0, rec_bytes.size());
      make_record(0, 5, 0, FillOnes, FaultNone);
      send_span(0, rec_bytes.size());
      make_record(0, 0, 7, FillZeros, FaultNone);
      send_span(0, rec_bytes.size());

      // A name past the truncation limit, streamed while the result side
      // holds off long enough for the block to fill up and stall its input.
      hold_rsp = 1'b1;
      make_record(NameMax, 1, 1, FillRandom, FaultNone);
      send_span(0, rec_bytes.size());

      // Last expected entry, then a record past the count that is dropped.
      drain();
      write_csr(CsrEntries, {16'($urandom_range(0, 65535)), 16'(board.done_count + 1)});
      make_record(2, 1, 0, FillRandom, FaultNone);
      send_span(0, rec_bytes.size());
      make_record(4, 0, 0, FillRandom, FaultNone);
      send_span(0, rec_bytes.size());
      drain();
      write_csr(CsrEntries, 32'h0000_FFFF);

      // Entry count lowered in the middle of a record, then raised again.
      make_record(5, 2, 2, FillRandom, FaultNone);
      send_span(0, 20);
      drain();
      write_csr(CsrEntries, 32'(board.done_count - 16'($urandom_range(0, 1))));
      send_noise(6);
      drain();
      write_csr(CsrEntries, 32'h0000_FFFF);
      send_span(20, rec_bytes.size());

      // Random records; each time the count runs out some trailing bytes are
      // sent, the entry count is set anew and sometimes the directory size too.
      drain();
      write_csr(CsrEntries, 32'(board.done_count + 3));
      useful = 0;
      while (useful < RandomBytes) begin
         if (board.done_count >= board.entry_limit) begin
            send_noise($urandom_range(1, 20));
            drain();
            if ($urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 1) == 0) begin
                  write_csr(CsrDirSize, 32'hFFFF_FFFF);
               end else begin
                  write_csr(CsrDirSize, board.rec_base + 32'd100000 +
                                        32'($urandom_range(0, 32'h3FFF_FFFF)));
               end
            end
            if ($urandom_range(0, 3) == 0) begin
               write_csr(CsrEntries, 32'h0000_FFFF);
            end else begin
               write_csr(CsrEntries, {16'($urandom_range(0, 65535)),
                                      16'(board.done_count + $urandom_range(1, 5))});
            end
         end
         case ($urandom_range(0, 15))
            0, 1, 2: begin
               nlen = 0;
               xlen = 0;
               clen = 0;
            end
            3: begin
               nlen = $urandom_range(NameMax - 3, NameMax + 20);
               xlen = $urandom_range(0, 3);
               clen = $urandom_range(0, 3);
            end
            default: begin
               nlen = $urandom_range(0, 16);
               xlen = $urandom_range(0, 6);
               clen = $urandom_range(0, 6);
            end
         endcase
         case ($urandom_range(0, 7))
            0:       fill = FillZeros;
            1:       fill = FillOnes;
            default: fill = FillRandom;
         endcase
         make_record(nlen, xlen, clen, fill, FaultNone);
         send_span(0, rec_bytes.size());
         useful += rec_bytes.size();
      end

      // One broken record ends parsing; the bytes after it are dropped.
      drain();
      write_csr(CsrEntries, 32'h0000_FFFF);
      case (2'($urandom_range(0, 3)))
         ErrHeaderPastEnd: begin
            write_csr(CsrDirSize, board.rec_base +
                      32'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 45)));
            make_record(2, 0, 0, FillRandom, FaultNone);
         end
         ErrBadSignature: make_record(3, 1, 1, FillRandom, FaultSignature);
         ErrEncrypted:    make_record(3, 1, 1, FillRandom, FaultEncrypted);
         default: begin
            nlen = $urandom_range(0, 8);
            xlen = $urandom_range(0, 4);
            clen = $urandom_range(1, 4);
            write_csr(CsrDirSize, board.rec_base +
                      32'(FixedBytes + $urandom_range(0, nlen + xlen + clen - 1)));
            make_record(nlen, xlen, clen, FillRandom, FaultNone);
         end
      endcase
      send_span(0, rec_bytes.size());
      send_noise($urandom_range(5, 20));

      // Let the last words drain, then a few more cycles for stray words.
      req_tvalid <= 1'b0;
      while (board.due_words.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

### zip_central_directory_parser.f
sv/zcdp_pkg.sv
sv/zcdp_result_queue.sv
sv/zip_central_directory_parser.sv
bench/tb_top.sv
